>>> rtl/citr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the CAN identifier tracker.
// No dependencies.
package citr_pkg;

  localparam int TABLE_DEPTH = 6;
  localparam int ID_W        = 11;

  typedef logic [ID_W-1:0] id_t;

  localparam id_t GYRO_ID  = 11'h100;
  localparam id_t ACCEL_ID = 11'h101;

  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_OTHER = 2'd0;
  localparam kind_t KIND_GYRO  = 2'd1;
  localparam kind_t KIND_ACCEL = 2'd2;

  typedef struct packed {
    logic load_in;   // capture the accepted item
    logic eval;      // match check, flag update, slot 0 replace
    logic swap;      // one bubble step
    logic load_out;  // copy state into the result register
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_req;  // item is a flag clear
    logic hit;        // identifier already in table
    logic sort_last;  // current bubble step is the final one
  } dp_status_t;

endpackage

>>> rtl/citr_dp.sv
`timescale 1ns / 1ps
// Datapath: sorted identifier table, IMU flags, bubble step logic, result register.
// Depends on citr_pkg.
module citr_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  citr_pkg::ctl_cmd_t                    cmd,
  output citr_pkg::dp_status_t                  status,
  input  logic                                  req_type,
  input  citr_pkg::id_t                         std_id,
  output citr_pkg::id_t [citr_pkg::TABLE_DEPTH-1:0] slot_out,
  output logic                                  gyro_out,
  output logic                                  accel_out,
  output citr_pkg::kind_t                       kind_out
);
  import citr_pkg::*;

  id_t                    tbl [TABLE_DEPTH];
  logic                   req_q;
  id_t                    id_q;
  logic                   gyro;
  logic                   accel;
  kind_t                  kind;
  logic [TABLE_DEPTH-2:0] pos;   // one-hot bubble position
  logic [TABLE_DEPTH-2:0] gt;
  logic                   gt_sel;
  logic                   hit;

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tbl[i] == id_q) hit = 1'b1;
    end
    for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
      gt[i] = tbl[i] > tbl[i+1];
    end
    gt_sel = |(pos & gt);
  end

  assign status.clear_req = req_q;
  assign status.hit       = hit;
  assign status.sort_last = !gt_sel || pos[TABLE_DEPTH-2];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_q <= req_type;
      id_q  <= std_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) tbl[i] <= '0;
      gyro  <= 1'b0;
      accel <= 1'b0;
      kind  <= KIND_OTHER;
      pos   <= '0;
    end else begin
      if (cmd.eval) begin
        if (req_q == REQ_CLEAR) begin
          gyro  <= 1'b0;
          accel <= 1'b0;
          kind  <= KIND_OTHER;
        end else begin
          if (id_q == GYRO_ID) begin
            gyro <= 1'b1;
            kind <= KIND_GYRO;
          end else if (id_q == ACCEL_ID) begin
            accel <= 1'b1;
            kind  <= KIND_ACCEL;
          end else begin
            kind <= KIND_OTHER;
          end
          if (!hit) tbl[0] <= id_q;
        end
        pos <= {{(TABLE_DEPTH-2){1'b0}}, 1'b1};
      end
      if (cmd.swap && gt_sel) begin
        for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
          if (pos[i]) begin
            tbl[i]   <= tbl[i+1];
            tbl[i+1] <= tbl[i];
          end
        end
        pos <= pos << 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      for (int i = 0; i < TABLE_DEPTH; i++) slot_out[i] <= tbl[i];
      gyro_out  <= gyro;
      accel_out <= accel;
      kind_out  <= kind;
    end
  end

endmodule

>>> rtl/citr_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences accept, match check, bubble steps and result hand-off.
// Depends on citr_pkg.
module citr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output citr_pkg::ctl_cmd_t   cmd,
  input  citr_pkg::dp_status_t status
);
  import citr_pkg::*;

  typedef enum logic [3:0] {
    IDLE  = 4'b0001,
    MATCH = 4'b0010,
    SORT  = 4'b0100,
    DONE  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.load_in  = 1'b0;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = MATCH;
        end
      end
      MATCH: begin
        cmd.eval = 1'b1;
        if (status.clear_req || status.hit) state_next = DONE;
        else state_next = SORT;
      end
      SORT: begin
        cmd.swap = 1'b1;
        if (status.sort_last) state_next = DONE;
      end
      DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

>>> rtl/can_id_tracker_and_imu_frame_router.sv
`timescale 1ns / 1ps
// Top level: CAN identifier tracker with IMU frame flags.
// Depends on citr_pkg, citr_ctrl, citr_dp.
//
//  channel | signals                         | direction
//  --------+---------------------------------+----------
//  in      | in_valid/in_ready, req_type,    | in
//          | std_id                          |
//  out     | out_valid/out_ready, id_slot0-5,| out
//          | gyro_updated, accel_updated,    |
//          | frame_kind                      |
//
// An item goes from accept through a match check, then the bubble steps of the new
// identifier (up to 5, none for a hit or a clear), then hand-off.
// The next item is accepted while a result still waits in the output register.
// rst is synchronous and clears the table, the flags and the handshake state.
module can_id_tracker_and_imu_frame_router (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  citr_pkg::id_t         std_id,
  output logic                  out_valid,
  input  logic                  out_ready,
  output citr_pkg::id_t         id_slot0,
  output citr_pkg::id_t         id_slot1,
  output citr_pkg::id_t         id_slot2,
  output citr_pkg::id_t         id_slot3,
  output citr_pkg::id_t         id_slot4,
  output citr_pkg::id_t         id_slot5,
  output logic                  gyro_updated,
  output logic                  accel_updated,
  output citr_pkg::kind_t       frame_kind
);
  import citr_pkg::*;

  ctl_cmd_t                 cmd;
  dp_status_t               status;
  id_t [TABLE_DEPTH-1:0]    slots;

  citr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  citr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req_type  (req_type),
    .std_id    (std_id),
    .slot_out  (slots),
    .gyro_out  (gyro_updated),
    .accel_out (accel_updated),
    .kind_out  (frame_kind)
  );

  assign id_slot0 = slots[0];
  assign id_slot1 = slots[1];
  assign id_slot2 = slots[2];
  assign id_slot3 = slots[3];
  assign id_slot4 = slots[4];
  assign id_slot5 = slots[5];

endmodule

>>> verif/can_id_tracker_and_imu_frame_router_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for can_id_tracker_and_imu_frame_router: sends identifiers and
// flag clears, predicts the sorted seen table and IMU flags, and checks every result.
// Depends on citr_pkg and the tracker RTL.
module can_id_tracker_and_imu_frame_router_tb;
  import citr_pkg::*;

  localparam int CLK_HALF   = 6;
  localparam int RST_CYCLES = 9;
  localparam int LONG_STALL = 300;
  localparam int WDOG_LIMIT = 3000;
  localparam int DRAIN_WAIT = 20;
  localparam int MAX_REPORT = 10;

  typedef struct packed {
    logic req;
    id_t  id;
  } can_item_t;

  typedef struct packed {
    id_t [TABLE_DEPTH-1:0] slots;
    logic                  gyro;
    logic                  accel;
    kind_t                 kind;
  } snapshot_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_ready;
  logic  req_type = REQ_FRAME;
  id_t   std_id = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  id_t   id_slot0, id_slot1, id_slot2, id_slot3, id_slot4, id_slot5;
  logic  gyro_updated, accel_updated;
  kind_t frame_kind;

  can_item_t frame_q[$];
  snapshot_t table_snapshot_q[$];

  // predicted block state
  id_t  seen_ids [TABLE_DEPTH];
  logic gyro_flag;
  logic accel_flag;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stall_token = 0;
  int stall_seen;
  int stall_left;
  int idle_cycles;
  int error_count = 0;

  can_id_tracker_and_imu_frame_router i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .std_id        (std_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .id_slot0      (id_slot0),
    .id_slot1      (id_slot1),
    .id_slot2      (id_slot2),
    .id_slot3      (id_slot3),
    .id_slot4      (id_slot4),
    .id_slot5      (id_slot5),
    .gyro_updated  (gyro_updated),
    .accel_updated (accel_updated),
    .frame_kind    (frame_kind)
  );

  always #CLK_HALF clk = ~clk;

  function automatic snapshot_t predict_table_update(can_item_t it);
    snapshot_t s;
    id_t       t;
    logic      hit;
    s.kind = KIND_OTHER;
    if (it.req == REQ_CLEAR) begin
      gyro_flag  = 1'b0;
      accel_flag = 1'b0;
    end else begin
      if (it.id == GYRO_ID) begin
        gyro_flag = 1'b1;
        s.kind    = KIND_GYRO;
      end else if (it.id == ACCEL_ID) begin
        accel_flag = 1'b1;
        s.kind     = KIND_ACCEL;
      end
      hit = 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (seen_ids[i] == it.id) hit = 1'b1;
      if (!hit) begin
        // new id replaces the smallest entry, then bubbles up to its place
        seen_ids[0] = it.id;
        for (int i = 0; i + 1 < TABLE_DEPTH; i++) begin
          if (seen_ids[i] <= seen_ids[i+1]) break;
          t             = seen_ids[i];
          seen_ids[i]   = seen_ids[i+1];
          seen_ids[i+1] = t;
        end
      end
    end
    for (int i = 0; i < TABLE_DEPTH; i++) s.slots[i] = seen_ids[i];
    s.gyro  = gyro_flag;
    s.accel = accel_flag;
    return s;
  endfunction

  // Mix of IMU ids, a narrow band around them and near zero (hits and churn),
  // full-range ids and clears.
  function automatic can_item_t random_frame();
    can_item_t it;
    int        pick;
    pick   = $urandom_range(99);
    it.req = REQ_FRAME;
    it.id  = id_t'($urandom_range(2047));
    if (pick < 8)       it.req = REQ_CLEAR;
    else if (pick < 20) it.id = GYRO_ID;
    else if (pick < 32) it.id = ACCEL_ID;
    else if (pick < 55) it.id = id_t'(11'h0FC + $urandom_range(9));
    else if (pick < 65) it.id = id_t'($urandom_range(5));
    return it;
  endfunction

  task automatic push_frame(logic req, id_t id);
    frame_q.push_back(can_item_t'({req, id}));
  endtask

  task automatic wait_drained();
    while (frame_q.size() != 0 || in_valid || table_snapshot_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(int n, int send_pct, int recv_pct);
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n) frame_q.push_back(random_frame());
    wait_drained();
  endtask

  // Sender: predicts on accept, then offers the next queued item or idles.
  always @(posedge clk) begin : driver
    can_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        table_snapshot_q.push_back(predict_table_update(can_item_t'({req_type, std_id})));
      if (!in_valid || in_ready) begin
        if (frame_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = frame_q.pop_front();
          in_valid <= 1'b1;
          req_type <= nxt.req;
          std_id   <= nxt.id;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started each time stall_token moves.
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
      stall_seen <= 0;
    end else if (stall_token != stall_seen) begin
      stall_left <= LONG_STALL;
      stall_seen <= stall_token;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin : monitor
    snapshot_t exp_s;
    snapshot_t act_s;
    logic      bad;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        act_s.slots = {id_slot5, id_slot4, id_slot3, id_slot2, id_slot1, id_slot0};
        act_s.gyro  = gyro_updated;
        act_s.accel = accel_updated;
        act_s.kind  = frame_kind;
        if (table_snapshot_q.size() == 0) begin
          error_count <= error_count + 1;
          if (error_count < MAX_REPORT)
            $display("%0t: result with nothing pending: slots %h g %b a %b kind %0d",
                     $time, act_s.slots, act_s.gyro, act_s.accel, act_s.kind);
        end else begin
          exp_s = table_snapshot_q.pop_front();
          bad   = 1'b0;
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (act_s.slots[i] !== exp_s.slots[i]) bad = 1'b1;
          if (act_s.gyro !== exp_s.gyro)   bad = 1'b1;
          if (act_s.accel !== exp_s.accel) bad = 1'b1;
          if (act_s.kind !== exp_s.kind)   bad = 1'b1;
          if (bad) begin
            error_count <= error_count + 1;
            if (error_count < MAX_REPORT)
              $display("%0t: mismatch exp slots %h g %b a %b kind %0d, got slots %h g %b a %b kind %0d",
                       $time, exp_s.slots, exp_s.gyro, exp_s.accel, exp_s.kind,
                       act_s.slots, act_s.gyro, act_s.accel, act_s.kind);
          end
        end
      end
      out_ready <= (stall_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) seen_ids[i] = '0;
    gyro_flag  = 1'b0;
    accel_flag = 1'b0;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: id 0 hits the reset zeros, extremes, IMU ids and repeats,
    // clears with stray ids, table fill, inserts below / between / above
    push_frame(REQ_FRAME, 11'h000);
    push_frame(REQ_FRAME, 11'h7FF);
    push_frame(REQ_FRAME, GYRO_ID);
    push_frame(REQ_FRAME, ACCEL_ID);
    push_frame(REQ_CLEAR, GYRO_ID);
    push_frame(REQ_FRAME, GYRO_ID);
    push_frame(REQ_FRAME, GYRO_ID);
    push_frame(REQ_FRAME, ACCEL_ID);
    push_frame(REQ_CLEAR, 11'h7FF);
    push_frame(REQ_CLEAR, 11'h000);
    push_frame(REQ_FRAME, 11'h001);
    push_frame(REQ_FRAME, 11'h002);
    push_frame(REQ_FRAME, 11'h003);
    push_frame(REQ_FRAME, 11'h000);
    push_frame(REQ_FRAME, 11'h7FE);
    push_frame(REQ_FRAME, 11'h555);
    push_frame(REQ_FRAME, 11'h2AA);
    push_frame(REQ_FRAME, 11'h400);
    push_frame(REQ_FRAME, 11'h0FF);
    push_frame(REQ_FRAME, 11'h102);
    push_frame(REQ_FRAME, 11'h001);
    wait_drained();

    run_phase(200, 0, 0);
    run_phase(160, 80, 0);
    run_phase(160, 0, 80);
    run_phase(200, 35, 35);

    // receiver held off while the sender keeps offering, so the input backs up
    @(negedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    stall_token    = stall_token + 1;
    repeat (60) frame_q.push_back(random_frame());
    wait_drained();

    run_phase(120, 0, 0);

    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (error_count == 0 && table_snapshot_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
